>>> rtl/vertex_project_to_window_defines.svh
// assertion macros shared by the vertex projection rtl
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef VERTEX_PROJECT_TO_WINDOW_DEFINES_SVH
`define VERTEX_PROJECT_TO_WINDOW_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VPW_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vpw assertion failed");
`define VPW_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) else $error("vpw assertion failed");
`else
`define VPW_ASSERT(name, prop)
`define VPW_ASSERT_ALWAYS(name, prop)
`endif
`endif

>>> rtl/vpw_pkg.sv
// types and constants of the vertex projection unit
// no dependencies
package vpw_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int OP_W   = 2;
  localparam int RES_W  = 15;
  localparam int MEM_AW = 5;
  localparam int APB_AW = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_MV = 2'd0,
    OP_LOAD_PR = 2'd1,
    OP_PROJECT = 2'd2
  } op_e;

  localparam logic [APB_AW-1:0] REG_RES_X = 3'd0;
  localparam logic [APB_AW-1:0] REG_RES_Y = 3'd4;
  localparam logic [RES_W-1:0]  RES_X_RST = 15'd1024;
  localparam logic [RES_W-1:0]  RES_Y_RST = 15'd768;

  typedef struct packed {
    logic                we;
    logic [MEM_AW-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
  } mem_req_t;

  typedef struct packed {
    logic                start;
    logic [DATA_W-1:0]   num;
    logic [DATA_W-1:0]   den;
  } div_req_t;

endpackage

>>> rtl/vpw_if.sv
// valid/ready channel interfaces for input and result beats
// depends on vpw_pkg
interface vpw_in_if import vpw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         elem_index;
  logic signed [DATA_W-1:0] elem_value;
  logic signed [DATA_W-1:0] obj_x;
  logic signed [DATA_W-1:0] obj_y;
  logic signed [DATA_W-1:0] obj_z;
  modport source (output valid, op, elem_index, elem_value, obj_x, obj_y, obj_z,
                  input ready);
  modport sink (input valid, op, elem_index, elem_value, obj_x, obj_y, obj_z,
                output ready);
endinterface

interface vpw_out_if import vpw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] win_x;
  logic signed [DATA_W-1:0] win_y;
  logic signed [DATA_W-1:0] win_z;
  modport source (output valid, ok, win_x, win_y, win_z, input ready);
  modport sink (input valid, ok, win_x, win_y, win_z, output ready);
endinterface

>>> rtl/vpw_matrix_mem.sv
// matrix store: both 4x4 matrices in one synchronous memory, identity until written
// depends on vpw_pkg
module vpw_matrix_mem import vpw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  input  logic [MEM_AW-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int DEPTH = 1 << MEM_AW;
  localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic              rd_valid_q;
  logic [MEM_AW-1:0] rd_addr_q;
  logic [DATA_W-1:0] rd_raw_q;
  logic              diag;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rd_raw_q  <= mem_q[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign diag      = (rd_addr_q[3:2] == rd_addr_q[1:0]);
  assign rd_data_o = rd_valid_q ? rd_raw_q : (diag ? FX_ONE : '0);

endmodule

>>> rtl/vpw_divider.sv
// serial restoring divider: round(num * 2^frac / den), ties away from zero, saturated
// depends on vpw_pkg and the assertion macros
`include "vertex_project_to_window_defines.svh"
module vpw_divider import vpw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quo_o
);

  localparam int DW = DATA_W + 1 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;
  localparam logic [DW-1:0] Q_POS_MAX = DW'(32'h7FFF_FFFF);
  localparam logic [DW-1:0] Q_NEG_MAX = DW'(32'h8000_0000);

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     dvd_q, dvd_d;
  logic [DATA_W-1:0] ad_q, ad_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] an_abs, ad_abs;
  logic [DATA_W:0]   rem_sh;
  logic              ge;

  always_comb begin
    an_abs  = req_i.num[DATA_W-1] ? (~req_i.num + 1'b1) : req_i.num;
    ad_abs  = req_i.den[DATA_W-1] ? (~req_i.den + 1'b1) : req_i.den;
    rem_sh  = {rem_q, dvd_q[DW-1]};
    ge      = rem_sh >= {1'b0, ad_q};
    state_d = state_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    ad_d    = ad_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    quo_d   = quo_q;
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          dvd_d   = (DW'(an_abs) << FRAC_BITS) + DW'(ad_abs >> 1);
          ad_d    = ad_abs;
          rem_d   = '0;
          neg_d   = req_i.num[DATA_W-1] ^ req_i.den[DATA_W-1];
          cnt_d   = CW'(DW);
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        rem_d = ge ? DATA_W'(rem_sh - {1'b0, ad_q}) : rem_sh[DATA_W-1:0];
        dvd_d = {dvd_q[DW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = D_FIN;
        end
      end
      D_FIN: begin
        if (neg_q) begin
          quo_d = (dvd_q > Q_NEG_MAX) ? 32'h8000_0000 : (~dvd_q[DATA_W-1:0] + 1'b1);
        end else begin
          quo_d = (dvd_q > Q_POS_MAX) ? 32'h7FFF_FFFF : dvd_q[DATA_W-1:0];
        end
        done_d  = 1'b1;
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    ad_q  <= ad_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  `VPW_ASSERT_ALWAYS(a_done_pulse, done_o |=> !done_o)
  `VPW_ASSERT(a_start_idle, req_i.start |-> state_q == D_IDLE)
  `VPW_ASSERT(a_run_ends, (state_q == D_RUN && cnt_q == CW'(1)) |=> state_q == D_FIN)

endmodule

>>> rtl/vertex_project_to_window.sv
// vertex projection unit: matrix loads and point projection to window coordinates
// a project beat gives its result beat after 32 pipelined multiply-accumulates on one
// multiplier and three serial divides (no divides when clip w is zero); the next beat is
// taken as the result appears; load beats are written straight into the matrix store
// while idle; reset is asynchronous active low, matrices read as identity
// depends on vpw_pkg, vpw_if, vpw_matrix_mem, vpw_divider and the assertion macros
`include "vertex_project_to_window_defines.svh"
module vertex_project_to_window import vpw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vpw_in_if.sink            in_i,
  vpw_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int AW = 2 * DATA_W + 2;
  localparam int MW = 2 * (DATA_W + 2);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_WIN  = 3'd4;
  localparam logic [2:0] S_WFIN = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic signed [DATA_W-1:0] FX_ONE  = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [AW-1:0]     FX_HALF = AW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [AW-1:0]     S_MAX   = AW'(32'h7FFF_FFFF);
  localparam logic signed [AW-1:0]     S_MIN   = -AW'(33'h0_8000_0000);

  logic [RES_W-1:0] res_x_q, res_y_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_x_q <= RES_X_RST;
      res_y_q <= RES_Y_RST;
    end else if (cfg_wr) begin
      if (paddr == REG_RES_X) begin
        res_x_q <= pwdata[RES_W-1:0];
      end
      if (paddr == REG_RES_Y) begin
        res_y_q <= pwdata[RES_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_RES_X) begin
      prdata = DATA_W'(res_x_q);
    end else if (paddr == REG_RES_Y) begin
      prdata = DATA_W'(res_y_q);
    end
  end

  logic [2:0]               state_q, state_d;
  logic [5:0]               k_q, k_d;
  logic                     t1_v_q, t2_v_q;
  logic [4:0]               t1_k_q, t2_k_q;
  logic signed [DATA_W-1:0] obj_q [3];
  logic signed [DATA_W-1:0] eye_q [4];
  logic signed [DATA_W-1:0] clip_q [4];
  logic signed [DATA_W-1:0] win_q [3];
  logic signed [DATA_W-1:0] ndc_q;
  logic signed [AW-1:0]     acc_q;
  logic signed [MW-1:0]     mul_q;
  logic [1:0]               ci_q, ci_d;
  logic                     ok_q;
  logic                     out_v_q;
  logic                     out_ok_q;
  logic signed [DATA_W-1:0] out_x_q, out_y_q, out_z_q;

  mem_req_t                 mem_req;
  logic [MEM_AW-1:0]        rd_addr;
  logic [DATA_W-1:0]        rd_data;
  div_req_t                 div_req;
  logic                     div_done;
  logic [DATA_W-1:0]        div_quo;

  logic                     in_acc, issue, pipe_busy, out_free, out_load;
  logic signed [DATA_W-1:0] vec;
  logic signed [DATA_W+1:0] mul_a, mul_b;
  logic signed [AW-1:0]     sum, sum_sh;
  logic signed [DATA_W-1:0] row_res, win_res;
  logic [RES_W-1:0]         res_sel;
  logic signed [49:0]       wt, wt_sh;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign pipe_busy  = t1_v_q | t2_v_q;
  assign issue      = (state_q == S_MAC) && !k_q[5] && !(k_q[4:0] == 5'd16 && pipe_busy);
  assign rd_addr    = {k_q[4], k_q[1:0], k_q[3:2]};
  assign out_free   = !out_v_q || out_o.ready;
  assign out_load   = (state_q == S_OUT) && out_free;

  always_comb begin
    mem_req.we    = in_acc && (in_i.op == OP_LOAD_MV || in_i.op == OP_LOAD_PR);
    mem_req.addr  = {in_i.op == OP_LOAD_PR, in_i.elem_index};
    mem_req.wdata = in_i.elem_value;
  end

  vpw_matrix_mem #(.FRAC_BITS(FRAC_BITS)) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    div_req.start = (state_q == S_DIV) && (clip_q[3] != '0);
    div_req.num   = clip_q[ci_q];
    div_req.den   = clip_q[3];
  end

  vpw_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quo_o (div_quo)
  );

  // shared multiplier operands
  always_comb begin
    if (t1_k_q[4]) begin
      vec = eye_q[t1_k_q[1:0]];
    end else if (t1_k_q[1:0] == 2'd3) begin
      vec = FX_ONE;
    end else begin
      vec = obj_q[t1_k_q[1:0]];
    end
    unique case (ci_q)
      2'd0:    res_sel = res_x_q;
      2'd1:    res_sel = res_y_q;
      default: res_sel = RES_W'(1);
    endcase
    if (state_q == S_WIN) begin
      mul_a = (DATA_W+2)'(ndc_q) + (DATA_W+2)'(FX_ONE);
      mul_b = (DATA_W+2)'(res_sel);
    end else begin
      mul_a = (DATA_W+2)'($signed(rd_data));
      mul_b = (DATA_W+2)'(vec);
    end
  end

  // row accumulation and window scaling, each with rounding and saturation
  always_comb begin
    sum    = ((t2_k_q[1:0] == 2'd0) ? FX_HALF : acc_q) + AW'($signed(mul_q[2*DATA_W-1:0]));
    sum_sh = sum >>> FRAC_BITS;
    if (sum_sh > S_MAX) begin
      row_res = 32'sh7FFF_FFFF;
    end else if (sum_sh < S_MIN) begin
      row_res = 32'sh8000_0000;
    end else begin
      row_res = sum_sh[DATA_W-1:0];
    end
    wt    = mul_q[49:0] + 50'sd1;
    wt_sh = wt >>> 1;
    if (wt_sh > 50'sh0_7FFF_FFFF) begin
      win_res = 32'sh7FFF_FFFF;
    end else if (wt_sh < -50'sh0_8000_0000) begin
      win_res = 32'sh8000_0000;
    end else begin
      win_res = wt_sh[DATA_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ci_d    = ci_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.op == OP_PROJECT) begin
          k_d     = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        if (issue) begin
          k_d = k_q + 1'b1;
        end
        if (k_q[5] && !pipe_busy) begin
          ci_d    = '0;
          state_d = S_DIV;
        end
      end
      S_DIV:  state_d = (clip_q[3] == '0) ? S_OUT : S_DIVW;
      S_DIVW: state_d = div_done ? S_WIN : S_DIVW;
      S_WIN:  state_d = S_WFIN;
      S_WFIN: begin
        if (ci_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          ci_d    = ci_q + 1'b1;
          state_d = S_DIV;
        end
      end
      S_OUT:  state_d = out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      ci_q    <= '0;
      t1_v_q  <= 1'b0;
      t2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ci_q    <= ci_d;
      t1_v_q  <= issue;
      t2_v_q  <= t1_v_q;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t1_k_q <= k_q[4:0];
    t2_k_q <= t1_k_q;
    if (t1_v_q || state_q == S_WIN) begin
      mul_q <= mul_a * mul_b;
    end
    if (in_acc) begin
      obj_q[0] <= in_i.obj_x;
      obj_q[1] <= in_i.obj_y;
      obj_q[2] <= in_i.obj_z;
      ok_q     <= 1'b1;
    end
    if (t2_v_q) begin
      acc_q <= sum;
      if (t2_k_q[1:0] == 2'd3) begin
        if (t2_k_q[4]) begin
          clip_q[t2_k_q[3:2]] <= row_res;
        end else begin
          eye_q[t2_k_q[3:2]] <= row_res;
        end
      end
    end
    if (state_q == S_DIV && clip_q[3] == '0) begin
      ok_q     <= 1'b0;
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end
    if (state_q == S_DIVW && div_done) begin
      ndc_q <= div_quo;
    end
    if (state_q == S_WFIN) begin
      win_q[ci_q] <= win_res;
    end
    if (out_load) begin
      out_ok_q <= ok_q;
      out_x_q  <= win_q[0];
      out_y_q  <= win_q[1];
      out_z_q  <= win_q[2];
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.ok    = out_ok_q;
  assign out_o.win_x = out_x_q;
  assign out_o.win_y = out_y_q;
  assign out_o.win_z = out_z_q;

  `VPW_ASSERT(a_load_idle, mem_req.we |-> state_q == S_IDLE)
  `VPW_ASSERT(a_mac_only, t1_v_q |-> state_q == S_MAC)
  `VPW_ASSERT(a_out_wait, (state_q == S_OUT && !out_free) |=> state_q == S_OUT)

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the vertex projection unit: directed and random beats,
// a fixed-point projection predictor and an in-order scoreboard of window results
// depends on vpw_pkg, vpw_if and vertex_project_to_window
module tb_top import vpw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  typedef struct packed {
    logic              ok;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } win_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  vpw_in_if  in_if ();
  vpw_out_if out_if ();

  vertex_project_to_window #(.FRAC_BITS(FB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  logic signed [31:0] mv_m [16];
  logic signed [31:0] pr_m [16];
  logic [14:0] res_x, res_y;
  win_t win_q [$];
  int errors = 0;
  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;
  bit hold_out = 1'b0;

  function automatic longint sat(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint row_sum(logic signed [31:0] m [16], longint v [4], int r);
    longint hs, ls, p, h;
    hs = 0;
    ls = 64'sd1 << (FB - 1);
    for (int c = 0; c < 4; c++) begin
      p = longint'(m[c*4+r]) * v[c];
      h = fl_shift(p, FB);
      hs += h;
      ls += p - (h <<< FB);
    end
    return sat(hs + (ls >>> FB));
  endfunction

  function automatic longint div_near(longint n, longint d);
    logic [63:0] an, ad, q;
    bit neg;
    neg = (n < 0) != (d < 0);
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (an + ad / 2) / ad;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return sat(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic logic signed [31:0] to_win(longint ndc, longint res);
    return 32'(sat(fl_shift((ndc + (64'sd1 << FB)) * res + 1, 1)));
  endfunction

  function automatic win_t project_point(logic signed [31:0] x, y, z);
    longint o [4], e [4], c [4];
    win_t w;
    o[0] = x; o[1] = y; o[2] = z; o[3] = 64'sd1 << FB;
    for (int r = 0; r < 4; r++) e[r] = row_sum(mv_m, o, r);
    for (int r = 0; r < 4; r++) c[r] = row_sum(pr_m, e, r);
    w = '0;
    if (c[3] == 0) return w;
    w.ok = 1'b1;
    w.wx = to_win(div_near(c[0] <<< FB, c[3]), res_x);
    w.wy = to_win(div_near(c[1] <<< FB, c[3]), res_y);
    w.wz = to_win(div_near(c[2] <<< FB, c[3]), 1);
    return w;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic send(logic [1:0] op, logic [3:0] idx, logic signed [31:0] v,
                      logic signed [31:0] x, y, z);
    int gap;
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.elem_index <= idx;
    in_if.elem_value <= v;
    in_if.obj_x <= x;
    in_if.obj_y <= y;
    in_if.obj_z <= z;
    do @(posedge clk_i); while (!in_if.ready);
    case (op)
      OP_LOAD_MV: mv_m[idx] = v;
      OP_LOAD_PR: pr_m[idx] = v;
      OP_PROJECT: win_q.push_back(project_point(x, y, z));
      default: ;
    endcase
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_if.valid <= 1'b0;
    while (win_q.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [APB_AW-1:0] a, logic [31:0] d);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == REG_RES_X) res_x = d[14:0];
    else res_y = d[14:0];
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  task automatic rnd_proj();
    send(OP_PROJECT, 4'($urandom), $urandom, rnd_val(), rnd_val(), rnd_val());
  endtask

  task automatic load_persp();
    for (int i = 0; i < 16; i++)
      send(OP_LOAD_PR, 4'(i), (i % 5 == 0 && i != 15) ? ONE : 32'sd0, 0, 0, 0);
    send(OP_LOAD_PR, 4'd11, -ONE, 0, 0, 0);
    send(OP_LOAD_PR, 4'd14, $signed($urandom_range(0, 3 * 65536)) - 2 * 65536, 0, 0, 0);
  endtask

  task automatic test_directed();
    send(OP_PROJECT, 0, 0, 0, 0, 0);
    send(OP_PROJECT, 4'hf, 32'hffffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send(OP_PROJECT, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send(OP_IGNORED, 4'hf, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send(OP_LOAD_PR, 4'd15, 0, 0, 0, 0);
    send(OP_PROJECT, 0, 0, ONE, ONE, ONE);
    send(OP_LOAD_PR, 4'd15, ONE, 0, 0, 0);
    send(OP_LOAD_MV, 4'd12, 32'sh7fffffff, 32'hffffffff, 0, 0);
    send(OP_LOAD_MV, 4'd0, 32'sh80000000, 0, 0, 0);
    send(OP_PROJECT, 0, 0, ONE, -ONE, 32'sd12345);
    send(OP_LOAD_MV, 4'd12, 0, 0, 0, 0);
    send(OP_LOAD_MV, 4'd0, ONE, 0, 0, 0);
    load_persp();
    send(OP_PROJECT, 0, 0, 32'sd100000, -32'sd70000, -32'sd200000);
    send(OP_PROJECT, 0, 0, 32'sd5, 32'sd5, 32'sd1);
    drain();
  endtask

  task automatic test_resolution();
    logic [31:0] rv [5] = '{32'd1, 32'd16384, 32'h7fff, 32'd0, 32'hffffffff};
    for (int k = 0; k < 5; k++) begin
      write_reg(REG_RES_X, rv[k]);
      write_reg(REG_RES_Y, rv[4-k]);
      for (int j = 0; j < 6; j++) rnd_proj();
      drain();
    end
    write_reg(REG_RES_X, 32'd1920);
    write_reg(REG_RES_Y, 32'd1080);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send(OP_LOAD_MV, 4'($urandom), rnd_val(), $urandom, $urandom, $urandom);
        1: send(OP_LOAD_PR, 4'($urandom), rnd_val(), $urandom, $urandom, $urandom);
        2: send(OP_IGNORED, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
        3: if ($urandom_range(0, 7) == 0) load_persp();
           else send(OP_LOAD_PR, 4'd15, $urandom_range(0, 1) ? 32'sd0 : ONE, 0, 0, 0);
        default: rnd_proj();
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_out = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_out = 1'b0;
      end
    join_none
    for (int i = 0; i < 12; i++) rnd_proj();
    drain();
  endtask

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      if (win_q.size() == 0) begin
        report("unexpected beat", out_if.win_x, 0);
      end else begin
        win_t w;
        w = win_q.pop_front();
        if (out_if.ok !== w.ok) report("ok", 32'(out_if.ok), 32'(w.ok));
        if (out_if.win_x !== w.wx) report("win_x", out_if.win_x, w.wx);
        if (out_if.win_y !== w.wy) report("win_y", out_if.win_y, w.wy);
        if (out_if.win_z !== w.wz) report("win_z", out_if.win_z, w.wz);
      end
    end
  end

  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        out_if.ready <= 1'b0;
        @(posedge clk_i);
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 17);
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_LOAD_MV;
    in_if.elem_index = '0;
    in_if.elem_value = '0;
    in_if.obj_x = '0;
    in_if.obj_y = '0;
    in_if.obj_z = '0;
    for (int i = 0; i < 16; i++) begin
      mv_m[i] = (i % 5 == 0) ? ONE : 32'sd0;
      pr_m[i] = (i % 5 == 0) ? ONE : 32'sd0;
    end
    res_x = RES_X_RST;
    res_y = RES_Y_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_resolution();
    test_backpressure();
    test_random(480);
    drain();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    test_random(150);
    drain();
    if (win_q.size() != 0) report("missing beats", 32'(win_q.size()), 0);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/vpw_pkg.sv
rtl/vpw_if.sv
rtl/vpw_matrix_mem.sv
rtl/vpw_divider.sv
rtl/vertex_project_to_window.sv
tb/sv/tb_top.sv
